// ===== hdl/bitmap_chunk_allocator_defines.svh =====
// ============================================================================
// Assertion macros for the bitmap chunk allocator
// Concurrent checks are clocked on clk and disabled while rst_n is low. They
// compile to nothing when SYNTHESIS is defined.
// ============================================================================
`ifndef BITMAP_CHUNK_ALLOCATOR_DEFINES_SVH
`define BITMAP_CHUNK_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define BCA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bitmap chunk allocator check failed");
// The consequent must hold in the cycle after the antecedent.
`define BCA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bitmap chunk allocator check failed");
`else
`define BCA_ASSERT_SAME(label, ante, cons)
`define BCA_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== hdl/bca_pkg.sv =====
// ============================================================================
// bca_pkg
// Types, sizes and codes shared by the bitmap chunk allocator.
// ============================================================================
package bca_pkg;

    // Region geometry.
    localparam int NUM_CHUNKS = 4096;
    localparam int IDX_W      = $clog2(NUM_CHUNKS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int TAG_W      = 8;

    // Field widths fixed by the interface.
    localparam int OPC_W   = 2;
    localparam int REQ_W   = 21;
    localparam int OFF_W   = 20;
    localparam int STAT_W  = 2;
    localparam int LOG2_W  = 4;
    localparam int USED_W  = 13;

    // Configuration port.
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;
    localparam logic REG_CHUNK_LOG2      = 1'b0;
    localparam logic REG_RESERVED_CHUNKS = 1'b1;

    localparam logic [LOG2_W-1:0] CHUNK_LOG2_RESET = 4'd4;
    localparam logic [LOG2_W-1:0] CHUNK_LOG2_MAX   = 4'd8;
    localparam logic [USED_W-1:0] RESERVED_RESET   = 13'd256;
    localparam logic [TAG_W-1:0]  RESERVED_TAG     = 8'd5;
    localparam logic [TAG_W-1:0]  FREE_TAG         = 8'd0;

    typedef enum logic [OPC_W-1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_INIT  = 2'd2
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_NO_SPACE  = 2'd1,
        STAT_BAD_FREE  = 2'd2,
        STAT_ZERO_SIZE = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_FILL,
        S_IDLE,
        S_ACHK,
        S_SCAN,
        S_LEFT,
        S_RIGHT,
        S_TAG,
        S_WRITE,
        S_FCHK,
        S_FTAG,
        S_FREE,
        S_FDONE,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic [OPC_W-1:0] opcode;
        logic [REQ_W-1:0] request_bytes;
        logic [OFF_W-1:0] free_offset;
    } in_item_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [OFF_W-1:0]  alloc_offset;
        logic [USED_W-1:0] used_count;
    } out_item_t;

endpackage

// ===== hdl/bitmap_chunk_allocator.sv =====
// ============================================================================
// bitmap_chunk_allocator
// Next-fit chunk allocator that keeps one owner tag per chunk in a RAM.
// ============================================================================
//
// Usage: requests arrive on in_valid/in_stall/in_item, and every request
// produces exactly one result on out_valid/out_stall/out_item. A request is
// taken when in_valid is high and in_stall is low; in_stall is low only while
// the sequencer is idle, so one request is worked on at a time. A finished
// result waits in the output register while the next request is accepted.
// The receiver may hold out_stall high for as long as it likes; the result
// stays put and the sequencer waits after its next request is finished.
//
// Steps, from acceptance to the result register:
//   allocate: a size check that may fail early, else a scan that reads one tag
//             per cycle from the single RAM read port (up to two passes over
//             the region in the worst case), neighbour reads and tag writes.
//   free:     an offset check and tag read, then the chunks of the run cleared.
//   init:     one RAM write per cycle over every chunk.
// After reset the tag RAM is cleared by a pass over all NUM_CHUNKS (4096)
// chunks, during which no request is taken. Configuration writes go through
// the APB port at any time and read back the stored values.
//
`include "bitmap_chunk_allocator_defines.svh"

module bitmap_chunk_allocator
    import bca_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              in_valid,
    output logic              in_stall,
    input  in_item_t          in_item,

    output logic              out_valid,
    input  logic              out_stall,
    output out_item_t         out_item,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    // The next tag is the left neighbor's tag plus one, skipped past zero and
    // past the right neighbor's tag. Two steps are always enough.
    function automatic logic [TAG_W-1:0] fresh_tag(input logic [TAG_W-1:0] l_tag,
                                                   input logic [TAG_W-1:0] r_tag);
        logic [TAG_W-1:0] t;
        t = l_tag + 8'd1;
        for (int i = 0; i < 2; i++)
        begin
            if (t == r_tag || t == FREE_TAG)
            begin
                t = t + 8'd1;
            end
        end
        return t;
    endfunction

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t            state_reg, state_next;
    logic [LOG2_W-1:0] log2_reg;
    logic [USED_W-1:0] resv_reg;
    logic [USED_W-1:0] used_reg, used_next;
    logic [IDX_W-1:0]  hint_reg, hint_next;

    logic [REQ_W-1:0]  req_reg, req_next;
    logic [OFF_W-1:0]  foff_reg, foff_next;
    logic [CNT_W-1:0]  need_reg, need_next;

    // Read pipeline: issue_pos goes to the RAM, data_pos tags the data that
    // comes back from the registered read port in the next cycle.
    logic [IDX_W-1:0]  issue_pos_reg, issue_pos_next;
    logic              issue_lap_reg, issue_lap_next;
    logic [IDX_W-1:0]  data_pos_reg, data_pos_next;
    logic              data_lap_reg, data_lap_next;
    logic              pipe_valid_reg, pipe_valid_next;

    logic [CNT_W-1:0]  run_len_reg, run_len_next;
    logic [IDX_W-1:0]  run_start_reg, run_start_next;
    logic [IDX_W-1:0]  start_reg, start_next;
    logic [TAG_W-1:0]  left_reg, left_next;
    logic [TAG_W-1:0]  tag_reg, tag_next;
    logic [IDX_W-1:0]  wr_pos_reg, wr_pos_next;
    logic [CNT_W-1:0]  wr_left_reg, wr_left_next;
    logic [TAG_W-1:0]  ftag_reg, ftag_next;
    logic [CNT_W-1:0]  clr_cnt_reg, clr_cnt_next;

    logic [IDX_W-1:0]  fill_pos_reg, fill_pos_next;
    logic [CNT_W-1:0]  fill_limit_reg, fill_limit_next;
    logic              fill_init_reg, fill_init_next;

    logic [STAT_W-1:0] res_status_reg, res_status_next;
    logic [OFF_W-1:0]  res_offset_reg, res_offset_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_item_reg, out_item_next;

    // ------------------------------------------------------------------
    // Tag memory: one write port, one registered read port.
    // ------------------------------------------------------------------
    logic [TAG_W-1:0]  tag_mem [NUM_CHUNKS];
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [TAG_W-1:0]  mem_wdata;
    logic [IDX_W-1:0]  mem_raddr;
    logic [TAG_W-1:0]  rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            tag_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= tag_mem[mem_raddr];
    end

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    logic cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_comb
    begin
        if (paddr[2] == REG_RESERVED_CHUNKS)
        begin
            prdata = DATA_W'(resv_reg);
        end
        else
        begin
            prdata = DATA_W'(log2_reg);
        end
    end

    // ------------------------------------------------------------------
    // Derived values
    // ------------------------------------------------------------------
    logic [LOG2_W-1:0] eff_log2;
    logic [CNT_W-1:0]  eff_resv;
    logic [CNT_W-1:0]  free_cnt;
    logic [REQ_W:0]    need_sum;
    logic [REQ_W:0]    need_full;
    logic              alloc_zero;
    logic              alloc_full;
    logic [CNT_W-1:0]  prior_len;
    logic              cur_free;
    logic [CNT_W-1:0]  scan_len;
    logic [IDX_W-1:0]  scan_start;
    logic              scan_found;
    logic              scan_fail;
    logic [CNT_W-1:0]  right_sum;
    logic              right_in;
    logic [TAG_W-1:0]  right_tag;
    logic [OFF_W-1:0]  foff_idx;
    logic              fidx_bad;
    logic              fmatch;
    logic              fend;
    logic              fill_last;
    logic              write_last;
    logic              in_fire;
    logic              emit_ok;

    always_comb
    begin
        eff_log2   = (log2_reg > CHUNK_LOG2_MAX) ? CHUNK_LOG2_MAX : log2_reg;
        eff_resv   = (resv_reg > USED_W'(NUM_CHUNKS)) ? CNT_W'(NUM_CHUNKS)
                                                      : CNT_W'(resv_reg);
        free_cnt   = CNT_W'(NUM_CHUNKS) - CNT_W'(used_reg);

        // Round the request up to whole chunks.
        need_sum   = {1'b0, req_reg} + (((REQ_W+1)'(1) << eff_log2) - (REQ_W+1)'(1));
        need_full  = need_sum >> eff_log2;
        alloc_zero = (req_reg == '0);
        alloc_full = (used_reg >= USED_W'(NUM_CHUNKS))
                  || (need_full > (REQ_W+1)'(free_cnt));

        // Free runs never wrap past the last chunk, so a run restarts at 0.
        prior_len  = (data_pos_reg == '0) ? '0 : run_len_reg;
        cur_free   = (rd_data_reg == FREE_TAG);
        scan_len   = cur_free ? prior_len + CNT_W'(1) : '0;
        scan_start = (prior_len == '0) ? data_pos_reg : run_start_reg;
        scan_found = pipe_valid_reg && cur_free && (scan_len == need_reg);
        scan_fail  = pipe_valid_reg && !scan_found && data_lap_reg && (&data_pos_reg);

        right_sum  = {1'b0, start_reg} + need_reg;
        right_in   = !right_sum[IDX_W];
        right_tag  = right_in ? rd_data_reg : FREE_TAG;

        foff_idx   = foff_reg >> eff_log2;
        fidx_bad   = (foff_idx >= OFF_W'(NUM_CHUNKS));
        fmatch     = pipe_valid_reg && (rd_data_reg == ftag_reg);
        fend       = pipe_valid_reg && (!fmatch || (&data_pos_reg));

        fill_last  = &fill_pos_reg;
        write_last = (wr_left_reg == CNT_W'(1));
        in_fire    = in_valid && (state_reg == S_IDLE);
        emit_ok    = !out_valid_reg || !out_stall;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_FILL:
            begin
                if (fill_last)
                begin
                    state_next = fill_init_reg ? S_EMIT : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (op_t'(in_item.opcode))
                        OP_ALLOC: state_next = S_ACHK;
                        OP_FREE:  state_next = S_FCHK;
                        OP_INIT:  state_next = S_FILL;
                        default:  state_next = S_EMIT;
                    endcase
                end
            end
            S_ACHK:
            begin
                state_next = (alloc_zero || alloc_full) ? S_EMIT : S_SCAN;
            end
            S_SCAN:
            begin
                priority if (scan_found)
                begin
                    state_next = S_LEFT;
                end
                else if (scan_fail)
                begin
                    state_next = S_EMIT;
                end
            end
            S_LEFT:  state_next = S_RIGHT;
            S_RIGHT: state_next = S_TAG;
            S_TAG:   state_next = S_WRITE;
            S_WRITE:
            begin
                if (write_last)
                begin
                    state_next = S_EMIT;
                end
            end
            S_FCHK:
            begin
                state_next = fidx_bad ? S_EMIT : S_FTAG;
            end
            S_FTAG:
            begin
                priority if (rd_data_reg == FREE_TAG)
                begin
                    state_next = S_EMIT;
                end
                else if (&data_pos_reg)
                begin
                    state_next = S_FDONE;
                end
                else
                begin
                    state_next = S_FREE;
                end
            end
            S_FREE:
            begin
                if (fend)
                begin
                    state_next = S_FDONE;
                end
            end
            S_FDONE: state_next = S_EMIT;
            S_EMIT:
            begin
                if (emit_ok)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: datapath and memory controls
    // ------------------------------------------------------------------
    always_comb
    begin
        used_next       = used_reg;
        hint_next       = hint_reg;
        req_next        = req_reg;
        foff_next       = foff_reg;
        need_next       = need_reg;
        issue_pos_next  = issue_pos_reg;
        issue_lap_next  = issue_lap_reg;
        data_pos_next   = data_pos_reg;
        data_lap_next   = data_lap_reg;
        pipe_valid_next = pipe_valid_reg;
        run_len_next    = run_len_reg;
        run_start_next  = run_start_reg;
        start_next      = start_reg;
        left_next       = left_reg;
        tag_next        = tag_reg;
        wr_pos_next     = wr_pos_reg;
        wr_left_next    = wr_left_reg;
        ftag_next       = ftag_reg;
        clr_cnt_next    = clr_cnt_reg;
        fill_pos_next   = fill_pos_reg;
        fill_limit_next = fill_limit_reg;
        fill_init_next  = fill_init_reg;
        res_status_next = res_status_reg;
        res_offset_next = res_offset_reg;
        out_item_next   = out_item_reg;
        out_valid_next  = out_valid_reg && out_stall;

        mem_we    = 1'b0;
        mem_waddr = wr_pos_reg;
        mem_wdata = FREE_TAG;
        mem_raddr = issue_pos_reg;

        unique case (state_reg)
            S_FILL:
            begin
                mem_we        = 1'b1;
                mem_waddr     = fill_pos_reg;
                mem_wdata     = ({1'b0, fill_pos_reg} < fill_limit_reg) ? RESERVED_TAG
                                                                        : FREE_TAG;
                fill_pos_next = fill_pos_reg + IDX_W'(1);
                if (fill_last && fill_init_reg)
                begin
                    used_next = USED_W'(fill_limit_reg);
                    hint_next = fill_limit_reg[IDX_W-1:0] - IDX_W'(1);
                end
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    req_next        = in_item.request_bytes;
                    foff_next       = in_item.free_offset;
                    res_status_next = STAT_OK;
                    res_offset_next = '0;
                    fill_pos_next   = '0;
                    fill_limit_next = eff_resv;
                    fill_init_next  = 1'b1;
                end
            end
            S_ACHK:
            begin
                need_next       = need_full[CNT_W-1:0];
                issue_pos_next  = hint_reg + IDX_W'(1);
                issue_lap_next  = &hint_reg;
                pipe_valid_next = 1'b0;
                run_len_next    = '0;
                priority if (alloc_zero)
                begin
                    res_status_next = STAT_ZERO_SIZE;
                end
                else if (alloc_full)
                begin
                    res_status_next = STAT_NO_SPACE;
                end
            end
            S_SCAN:
            begin
                mem_raddr       = issue_pos_reg;
                issue_pos_next  = issue_pos_reg + IDX_W'(1);
                issue_lap_next  = issue_lap_reg || (&issue_pos_reg);
                data_pos_next   = issue_pos_reg;
                data_lap_next   = issue_lap_reg;
                pipe_valid_next = 1'b1;
                if (pipe_valid_reg)
                begin
                    run_len_next   = scan_len;
                    run_start_next = scan_start;
                end
                if (scan_found)
                begin
                    start_next = scan_start;
                end
                if (scan_fail)
                begin
                    res_status_next = STAT_NO_SPACE;
                end
            end
            S_LEFT:
            begin
                mem_raddr = start_reg - IDX_W'(1);
            end
            S_RIGHT:
            begin
                mem_raddr = right_sum[IDX_W-1:0];
                left_next = (start_reg == '0) ? FREE_TAG : rd_data_reg;
            end
            S_TAG:
            begin
                tag_next     = fresh_tag(left_reg, right_tag);
                wr_pos_next  = start_reg;
                wr_left_next = need_reg;
            end
            S_WRITE:
            begin
                mem_we       = 1'b1;
                mem_waddr    = wr_pos_reg;
                mem_wdata    = tag_reg;
                wr_pos_next  = wr_pos_reg + IDX_W'(1);
                wr_left_next = wr_left_reg - CNT_W'(1);
                if (write_last)
                begin
                    hint_next       = start_reg + need_reg[IDX_W-1:0] - IDX_W'(2);
                    used_next       = used_reg + USED_W'(need_reg);
                    res_offset_next = OFF_W'(start_reg) << eff_log2;
                end
            end
            S_FCHK:
            begin
                mem_raddr     = foff_idx[IDX_W-1:0];
                data_pos_next = foff_idx[IDX_W-1:0];
                if (fidx_bad)
                begin
                    res_status_next = STAT_BAD_FREE;
                end
            end
            S_FTAG:
            begin
                if (rd_data_reg == FREE_TAG)
                begin
                    res_status_next = STAT_BAD_FREE;
                end
                else
                begin
                    mem_we          = 1'b1;
                    mem_waddr       = data_pos_reg;
                    mem_wdata       = FREE_TAG;
                    ftag_next       = rd_data_reg;
                    clr_cnt_next    = CNT_W'(1);
                    issue_pos_next  = data_pos_reg + IDX_W'(1);
                    pipe_valid_next = 1'b0;
                end
            end
            S_FREE:
            begin
                // Reads run one chunk ahead of the clearing writes.
                mem_raddr       = issue_pos_reg;
                issue_pos_next  = issue_pos_reg + IDX_W'(1);
                data_pos_next   = issue_pos_reg;
                pipe_valid_next = 1'b1;
                if (fmatch)
                begin
                    mem_we       = 1'b1;
                    mem_waddr    = data_pos_reg;
                    mem_wdata    = FREE_TAG;
                    clr_cnt_next = clr_cnt_reg + CNT_W'(1);
                end
            end
            S_FDONE:
            begin
                used_next = (CNT_W'(used_reg) > clr_cnt_reg)
                          ? used_reg - USED_W'(clr_cnt_reg) : '0;
            end
            S_EMIT:
            begin
                if (emit_ok)
                begin
                    out_valid_next             = 1'b1;
                    out_item_next.status       = res_status_reg;
                    out_item_next.alloc_offset = res_offset_reg;
                    out_item_next.used_count   = used_reg;
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_FILL;
            log2_reg       <= CHUNK_LOG2_RESET;
            resv_reg       <= RESERVED_RESET;
            used_reg       <= '0;
            hint_reg       <= '0;
            fill_pos_reg   <= '0;
            fill_limit_reg <= '0;
            fill_init_reg  <= 1'b0;
            pipe_valid_reg <= 1'b0;
            issue_lap_reg  <= 1'b0;
            data_lap_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            hint_reg       <= hint_next;
            fill_pos_reg   <= fill_pos_next;
            fill_limit_reg <= fill_limit_next;
            fill_init_reg  <= fill_init_next;
            pipe_valid_reg <= pipe_valid_next;
            issue_lap_reg  <= issue_lap_next;
            data_lap_reg   <= data_lap_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                if (paddr[2] == REG_RESERVED_CHUNKS)
                begin
                    resv_reg <= pwdata[USED_W-1:0];
                end
                else
                begin
                    log2_reg <= pwdata[LOG2_W-1:0];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        foff_reg       <= foff_next;
        need_reg       <= need_next;
        issue_pos_reg  <= issue_pos_next;
        data_pos_reg   <= data_pos_next;
        run_len_reg    <= run_len_next;
        run_start_reg  <= run_start_next;
        start_reg      <= start_next;
        left_reg       <= left_next;
        tag_reg        <= tag_next;
        wr_pos_reg     <= wr_pos_next;
        wr_left_reg    <= wr_left_next;
        ftag_reg       <= ftag_next;
        clr_cnt_reg    <= clr_cnt_next;
        res_status_reg <= res_status_next;
        res_offset_reg <= res_offset_next;
        out_item_reg   <= out_item_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // The tag RAM is written only by the fill, free and write-back steps.
    `BCA_ASSERT_SAME(a_mem_write_state, mem_we, state_reg == S_FILL || state_reg == S_FTAG || state_reg == S_FREE || state_reg == S_WRITE)
    // A scan leaves as soon as a run reaches the needed length.
    `BCA_ASSERT_SAME(a_scan_run_below_need, state_reg == S_SCAN, run_len_reg < need_reg)
    // The used count never exceeds the region.
    `BCA_ASSERT_SAME(a_used_bounded, rst_n, used_reg <= USED_W'(NUM_CHUNKS))
    // A taken result is dropped unless a new one is loaded in the same cycle.
    `BCA_ASSERT_NEXT(a_result_drained, out_valid && !out_stall && state_reg != S_EMIT, !out_valid)

endmodule
